// ===== src/rplc_pkg.sv =====
// Shared constants, codes and types for the ROM page cache.
package rplc_pkg;

   localparam int SLOTS         = 16;
   localparam int PAGE_BITS     = 9;
   localparam int SLOT_BITS     = $clog2(SLOTS);
   localparam int AGE_BITS      = 32;
   localparam int KB_BITS       = 13;
   localparam int PIN_BITS      = 9;
   localparam int PAGE_SHIFT    = 4;
   localparam int CFG_BITS      = 5;
   localparam int SLOTS_RESET   = 16;
   localparam int STATUS_BITS   = 2;
   localparam int SLOT_OUT_BITS = 4;
   localparam int EVICT_BITS    = 9;
   localparam int ADDR_BITS     = 3;
   localparam int DATA_BITS     = 32;
   localparam int REG_IDX_BITS  = 1;

   localparam logic [REG_IDX_BITS-1:0] REG_SLOTS_IN_USE = 1'b0;

   // request operation codes
   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_HIT   = 2'd0,
      STATUS_MISS  = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_FLUSH = 2'd3
   } status_type;

   // one slot entry presented to the scan unit per cycle
   typedef struct packed {
      logic                 clear;
      logic                 step;
      logic [SLOT_BITS-1:0] idx;
      logic                 valid;
      logic [PAGE_BITS-1:0] page;
      logic [AGE_BITS-1:0]  age;
      logic [PAGE_BITS-1:0] req_page;
      logic [PAGE_BITS-1:0] pin_a;
      logic [PAGE_BITS-1:0] pin_b;
   } scan_ctl_type;

   // running outcome of the scan
   typedef struct packed {
      logic                 hit;
      logic [SLOT_BITS-1:0] hit_idx;
      logic                 empty;
      logic [SLOT_BITS-1:0] empty_idx;
      logic                 cand;
      logic [SLOT_BITS-1:0] cand_idx;
      logic [PAGE_BITS-1:0] cand_page;
      logic [AGE_BITS-1:0]  oldest;
   } scan_res_type;

endpackage

// ===== src/rplc_scan.sv =====
// Slot scan unit: one entry per cycle, tracks hit, first empty and oldest unpinned slot.
module rplc_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  rplc_pkg::scan_ctl_type ctl,
   output rplc_pkg::scan_res_type res
);
   import rplc_pkg::*;

   scan_res_type res_ff, res_in;
   logic         page_match;
   logic         pinned;
   logic         older;

   always_comb begin
      page_match = (ctl.page == ctl.req_page);
      pinned     = (ctl.page == ctl.pin_a) || (ctl.page == ctl.pin_b);
      older      = (ctl.age < res_ff.oldest);   // the one shared age compare
      res_in     = res_ff;
      if (ctl.clear) begin
         res_in = '0;
      end else if (ctl.step) begin
         if (!res_ff.hit && ctl.valid && page_match) begin
            res_in.hit     = 1'b1;
            res_in.hit_idx = ctl.idx;
         end
         if (!res_ff.empty && !ctl.valid) begin
            res_in.empty     = 1'b1;
            res_in.empty_idx = ctl.idx;
         end
         // strict compare keeps the lowest index on ties
         if (ctl.valid && !pinned && (!res_ff.cand || older)) begin
            res_in.cand      = 1'b1;
            res_in.cand_idx  = ctl.idx;
            res_in.cand_page = ctl.page;
            res_in.oldest    = ctl.age;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ===== src/rom_page_cache_lru_pinned.sv =====
// Top level of the fully associative ROM page cache directory with LRU and pinned pages.
//
//  channel   ports                                   handshake
//  request   req_op, req_rom_kilobyte, req_pin_*     start high, busy low
//  result    rsp_status, rsp_slot, rsp_evict_*       rsp_valid, one cycle, no stall
//  config    psel penable pwrite paddr pwdata prdata APB read/write, pready always high
//
//  Access: accepted in idle, then the active slots (n = slots_in_use clamped
//  to 1..SLOTS) pass one slot per cycle through the shared scan unit, then
//  the update state runs; rsp_valid is registered and high in the cycle after it.
//  Flush skips the scan. A new item can be taken in the cycle that shows the result.
//  Reset (synchronous) empties the cache, zeroes the age clock, sets n to SLOTS.
//  Results cannot be held off; busy alone paces the requester.
module rom_page_cache_lru_pinned (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_op,
   input  logic [rplc_pkg::KB_BITS-1:0]          req_rom_kilobyte,
   input  logic [rplc_pkg::PIN_BITS-1:0]         req_pin_page_a,
   input  logic [rplc_pkg::PIN_BITS-1:0]         req_pin_page_b,
   output logic                                  rsp_valid,
   output logic [rplc_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [rplc_pkg::SLOT_OUT_BITS-1:0]    rsp_slot,
   output logic                                  rsp_evict_valid,
   output logic [rplc_pkg::EVICT_BITS-1:0]       rsp_evicted_page,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [rplc_pkg::ADDR_BITS-1:0]        paddr,
   input  logic [rplc_pkg::DATA_BITS-1:0]        pwdata,
   output logic [rplc_pkg::DATA_BITS-1:0]        prdata,
   output logic                                  pready
);
   import rplc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [SLOT_BITS-1:0]   idx_ff, idx_in;
   logic [SLOT_BITS-1:0]   last_ff, last_in;
   logic                   op_ff, op_in;
   logic [PAGE_BITS-1:0]   page_ff, page_in;
   logic [PAGE_BITS-1:0]   pin_a_ff, pin_a_in;
   logic [PAGE_BITS-1:0]   pin_b_ff, pin_b_in;
   logic [CFG_BITS-1:0]    slots_cfg_ff, slots_cfg_in;
   logic [SLOTS-1:0]       valid_ff, valid_in;
   logic [AGE_BITS-1:0]    age_clock_ff, age_clock_in;

   // slot directory, read only at the scan index
   logic [PAGE_BITS-1:0]   slot_page_ff [SLOTS];
   logic [AGE_BITS-1:0]    slot_age_ff  [SLOTS];
   logic                   wr_en;
   logic [SLOT_BITS-1:0]   wr_idx;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_BITS-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                   rsp_evict_ff, rsp_evict_in;
   logic [PAGE_BITS-1:0]   rsp_page_ff, rsp_page_in;

   logic                   accept;
   logic                   csr_write;
   logic [CFG_BITS-1:0]    slots_active;
   logic [AGE_BITS-1:0]    age_next;
   scan_ctl_type           scan_ctl;
   scan_res_type           scan_res;

   assign accept    = start && (state_ff == ST_IDLE);
   assign csr_write = psel && penable && pwrite && pready;
   assign busy      = (state_ff != ST_IDLE);
   assign pready    = 1'b1;
   assign age_next  = age_clock_ff + AGE_BITS'(1);

   // register reads
   always_comb begin
      prdata = '0;
      unique case (paddr[ADDR_BITS-1 -: REG_IDX_BITS])
         REG_SLOTS_IN_USE: prdata = DATA_BITS'(slots_cfg_ff);
         default:          prdata = '0;
      endcase
   end

   // zero acts as one, anything above the slot count as the slot count
   always_comb begin
      if (slots_cfg_ff == '0) begin
         slots_active = CFG_BITS'(1);
      end else if (32'(slots_cfg_ff) > SLOTS) begin
         slots_active = CFG_BITS'(SLOTS);
      end else begin
         slots_active = slots_cfg_ff;
      end
   end

   always_comb begin
      scan_ctl.clear    = accept;
      scan_ctl.step     = (state_ff == ST_SCAN);
      scan_ctl.idx      = idx_ff;
      scan_ctl.valid    = valid_ff[idx_ff];
      scan_ctl.page     = slot_page_ff[idx_ff];
      scan_ctl.age      = slot_age_ff[idx_ff];
      scan_ctl.req_page = page_ff;
      scan_ctl.pin_a    = pin_a_ff;
      scan_ctl.pin_b    = pin_b_ff;
   end

   rplc_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .res   (scan_res)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      op_in         = op_ff;
      page_in       = page_ff;
      pin_a_in      = pin_a_ff;
      pin_b_in      = pin_b_ff;
      slots_cfg_in  = slots_cfg_ff;
      valid_in      = valid_ff;
      age_clock_in  = age_clock_ff;
      wr_en         = 1'b0;
      wr_idx        = scan_res.cand_idx;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_evict_in  = rsp_evict_ff;
      rsp_page_in   = rsp_page_ff;

      if (csr_write && (paddr[ADDR_BITS-1 -: REG_IDX_BITS] == REG_SLOTS_IN_USE)) begin
         slots_cfg_in = pwdata[CFG_BITS-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               page_in  = PAGE_BITS'(req_rom_kilobyte >> PAGE_SHIFT);
               pin_a_in = PAGE_BITS'(req_pin_page_a);
               pin_b_in = PAGE_BITS'(req_pin_page_b);
               idx_in   = '0;
               last_in  = SLOT_BITS'(slots_active - CFG_BITS'(1));
               state_in = (req_op == OP_FLUSH) ? ST_FIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + SLOT_BITS'(1);
            if (idx_ff == last_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_slot_in   = '0;
            rsp_evict_in  = 1'b0;
            rsp_page_in   = '0;
            if (op_ff == OP_FLUSH) begin
               valid_in      = '0;
               age_clock_in  = '0;
               rsp_status_in = STATUS_FLUSH;
            end else if (scan_res.hit) begin
               wr_en         = 1'b1;
               wr_idx        = scan_res.hit_idx;
               age_clock_in  = age_next;
               rsp_status_in = STATUS_HIT;
               rsp_slot_in   = scan_res.hit_idx;
            end else if (scan_res.empty) begin
               wr_en            = 1'b1;
               wr_idx           = scan_res.empty_idx;
               valid_in[wr_idx] = 1'b1;
               age_clock_in     = age_next;
               rsp_status_in    = STATUS_MISS;
               rsp_slot_in      = scan_res.empty_idx;
            end else if (scan_res.cand) begin
               wr_en         = 1'b1;
               wr_idx        = scan_res.cand_idx;
               age_clock_in  = age_next;
               rsp_status_in = STATUS_MISS;
               rsp_slot_in   = scan_res.cand_idx;
               rsp_evict_in  = 1'b1;
               rsp_page_in   = scan_res.cand_page;
            end else begin
               // every usable slot pinned: nothing changes
               rsp_status_in = STATUS_FULL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         last_ff      <= '0;
         op_ff        <= OP_ACCESS;
         slots_cfg_ff <= CFG_BITS'(SLOTS_RESET);
         valid_ff     <= '0;
         age_clock_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
         op_ff        <= op_in;
         slots_cfg_ff <= slots_cfg_in;
         valid_ff     <= valid_in;
         age_clock_ff <= age_clock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      pin_a_ff      <= pin_a_in;
      pin_b_ff      <= pin_b_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_evict_ff  <= rsp_evict_in;
      rsp_page_ff   <= rsp_page_in;
      if (wr_en) begin
         // a hit rewrites the same page, so page and age update together
         slot_page_ff[wr_idx] <= page_ff;
         slot_age_ff[wr_idx]  <= age_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = SLOT_OUT_BITS'(rsp_slot_ff);
   assign rsp_evict_valid  = rsp_evict_ff;
   assign rsp_evicted_page = EVICT_BITS'(rsp_page_ff);

endmodule

// ===== src/rplc_checker.sv =====
// Port-level checks for the ROM page cache, bound to the top level.
module rplc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic [rplc_pkg::STATUS_BITS-1:0]   rsp_status,
   input logic [rplc_pkg::SLOT_OUT_BITS-1:0] rsp_slot,
   input logic                               rsp_evict_valid
);
   import rplc_pkg::*;

   // an accepted item keeps the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy low after an accepted item");

   // work ends exactly when its result shows
   a_result_at_done: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // one result per item, never two in a row
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back results");

   a_flush_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FLUSH || rsp_status == STATUS_FULL)
         |-> rsp_slot == '0 && !rsp_evict_valid)
      else $error("flush or full result carries a slot or eviction");

   a_evict_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evict_valid |-> rsp_status == STATUS_MISS)
      else $error("eviction reported without a miss");

endmodule

bind rom_page_cache_lru_pinned rplc_checker u_rplc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_slot        (rsp_slot),
   .rsp_evict_valid (rsp_evict_valid)
);

// ===== verif/rom_page_cache_lru_pinned_tb.sv =====
// Testbench for rom_page_cache_lru_pinned: directed and random items checked against a model.
`timescale 1ns / 1ps

module rom_page_cache_lru_pinned_tb;
   import rplc_pkg::*;

   // one request item as the sender presents it
   typedef struct packed {
      logic                op;
      logic [KB_BITS-1:0]  kb;
      logic [PIN_BITS-1:0] pin_a;
      logic [PIN_BITS-1:0] pin_b;
   } page_request_type;

   // one result item: lookup status, slot and eviction report
   typedef struct packed {
      status_type                status;
      logic [SLOT_OUT_BITS-1:0]  slot;
      logic                      evict_valid;
      logic [EVICT_BITS-1:0]     evicted_page;
   } page_outcome_type;

   // Tracks the page directory (valid, page, age per slot plus the age clock)
   // and holds the outcomes still owed by the block, oldest first.
   class lru_directory_check_type;
      bit                    valid_at[SLOTS];
      logic [PAGE_BITS-1:0]  page_at[SLOTS];
      logic [AGE_BITS-1:0]   age_at[SLOTS];
      logic [AGE_BITS-1:0]   age_clock;
      logic [CFG_BITS-1:0]   slot_count;
      page_outcome_type      pending_outcomes[$];
      int                    mismatches;

      function new();
         slot_count = CFG_BITS'(SLOTS_RESET);
         mismatches = 0;
         clear_all();
      endfunction

      function void clear_all();
         for (int j = 0; j < SLOTS; j++) begin
            valid_at[j] = 1'b0;
            page_at[j]  = '0;
            age_at[j]   = '0;
         end
         age_clock = '0;
      endfunction

      function void set_slot_count(logic [CFG_BITS-1:0] value);
         slot_count = value;
      endfunction

      // lookup, then first empty slot, then oldest unpinned slot (lowest index on ties)
      function page_outcome_type lookup_and_replace(page_request_type r);
         page_outcome_type     o;
         logic [PAGE_BITS-1:0] page;
         logic [AGE_BITS-1:0]  oldest;
         int                   n;
         int                   pick;
         bit                   got_one;
         bit                   empty_one;
         o.status       = STATUS_HIT;
         o.slot         = '0;
         o.evict_valid  = 1'b0;
         o.evicted_page = '0;
         oldest         = '0;
         pick           = 0;
         got_one        = 1'b0;
         empty_one      = 1'b0;
         if (r.op == OP_FLUSH) begin
            clear_all();
            o.status = STATUS_FLUSH;
            return o;
         end
         page = PAGE_BITS'(r.kb >> PAGE_SHIFT);
         // count of 0 acts as 1, anything above SLOTS as SLOTS
         n = int'(slot_count);
         if (n < 1) n = 1;
         if (n > SLOTS) n = SLOTS;
         for (int j = 0; j < n; j++) begin
            if (valid_at[j] && page_at[j] == page) begin
               age_clock = age_clock + 1;
               age_at[j] = age_clock;
               o.slot    = SLOT_OUT_BITS'(j);
               return o;
            end
         end
         for (int j = 0; j < n; j++) begin
            if (!valid_at[j]) begin
               pick      = j;
               got_one   = 1'b1;
               empty_one = 1'b1;
               break;
            end
            if (page_at[j] == r.pin_a || page_at[j] == r.pin_b) continue;
            if (!got_one || age_at[j] < oldest) begin
               oldest  = age_at[j];
               pick    = j;
               got_one = 1'b1;
            end
         end
         if (!got_one) begin
            // everything pinned: no state change, clock holds
            o.status = STATUS_FULL;
            return o;
         end
         o.status = STATUS_MISS;
         o.slot   = SLOT_OUT_BITS'(pick);
         if (!empty_one) begin
            o.evict_valid  = 1'b1;
            o.evicted_page = EVICT_BITS'(page_at[pick]);
         end
         valid_at[pick] = 1'b1;
         page_at[pick]  = page;
         age_clock      = age_clock + 1;
         age_at[pick]   = age_clock;
         return o;
      endfunction

      function void note_request(page_request_type r);
         pending_outcomes.push_back(lookup_and_replace(r));
      endfunction

      function void check_outcome(page_outcome_type seen);
         page_outcome_type want;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with nothing pending: status %0d slot %0d %0b %0d",
                        $time, seen.status, seen.slot, seen.evict_valid,
                        seen.evicted_page);
            return;
         end
         want = pending_outcomes.pop_front();
         if (seen.status !== want.status || seen.slot !== want.slot ||
             seen.evict_valid !== want.evict_valid ||
             seen.evicted_page !== want.evicted_page) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch exp status %0d slot %0d evict %0b page %0d,",
                        $time, want.status, want.slot, want.evict_valid,
                        want.evicted_page,
                        " got %0d %0d %0b %0d",
                        seen.status, seen.slot, seen.evict_valid, seen.evicted_page);
         end
      endfunction
   endclass

   // no item in or out for this long means the block hung
   localparam int STALL_LIMIT    = 3000;
   localparam int ITEMS_PER_MODE = 70;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic                        req_op;
   logic [KB_BITS-1:0]          req_rom_kilobyte;
   logic [PIN_BITS-1:0]         req_pin_page_a;
   logic [PIN_BITS-1:0]         req_pin_page_b;
   logic                        rsp_valid;
   logic [STATUS_BITS-1:0]      rsp_status;
   logic [SLOT_OUT_BITS-1:0]    rsp_slot;
   logic                        rsp_evict_valid;
   logic [EVICT_BITS-1:0]       rsp_evicted_page;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [ADDR_BITS-1:0]        paddr;
   logic [DATA_BITS-1:0]        pwdata;
   logic [DATA_BITS-1:0]        prdata;
   logic                        pready;

   lru_directory_check_type dir_check;
   int                      quiet_cycles;
   bit                      gaps_on;

   rom_page_cache_lru_pinned dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_rom_kilobyte (req_rom_kilobyte),
      .req_pin_page_a   (req_pin_page_a),
      .req_pin_page_b   (req_pin_page_b),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_evict_valid  (rsp_evict_valid),
      .rsp_evicted_page (rsp_evicted_page),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #2 clock = ~clock;

   // Result monitor. Outputs are sampled at the rising edge, before the
   // block's own flops update, so what we see is the item that just ended.
   always @(posedge clock) begin : result_monitor
      page_outcome_type seen;
      if (!reset && rsp_valid) begin
         seen.status       = status_type'(rsp_status);
         seen.slot         = rsp_slot;
         seen.evict_valid  = rsp_evict_valid;
         seen.evicted_page = rsp_evicted_page;
         dir_check.check_outcome(seen);
      end
   end

   // Watchdog: any accepted request, result or register access resets it.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Present one item at the falling edge and hold it until the block takes it.
   // Returns at the next falling edge with start still high, so back-to-back
   // items drop start between them only for a random gap while gaps_on is set.
   task automatic send_request(input page_request_type r);
      if (gaps_on && $urandom_range(0, 99) < 10) begin
         start = 1'b0;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
      start            = 1'b1;
      req_op           = r.op;
      req_rom_kilobyte = r.kb;
      req_pin_page_a   = r.pin_a;
      req_pin_page_b   = r.pin_b;
      do @(posedge clock); while (busy);
      dir_check.note_request(r);
      @(negedge clock);
   endtask

   // Stop sending and wait for every owed result; the block is idle after that.
   task automatic wait_drained();
      start = 1'b0;
      while (dir_check.pending_outcomes.size() != 0) @(negedge clock);
   endtask

   // Register write (setup + access), then read it back.
   task automatic write_slot_count(input logic [CFG_BITS-1:0] value);
      wait_drained();
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = ADDR_BITS'({REG_SLOTS_IN_USE, 2'b00});
      pwdata  = DATA_BITS'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      dir_check.set_slot_count(value);
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== DATA_BITS'(value)) begin
         dir_check.mismatches++;
         if (dir_check.mismatches <= 10)
            $display("%0t: slot count readback exp %0d got %0d", $time, value, prdata);
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // Pins mostly name pages really in the cache so the skip logic gets work.
   function automatic logic [PIN_BITS-1:0] pick_pin(logic [PAGE_BITS-1:0] pool_base, int n);
      int roll;
      int s;
      roll = $urandom_range(0, 99);
      s    = $urandom_range(0, n - 1);
      if (roll < 55 && dir_check.valid_at[s]) return PIN_BITS'(dir_check.page_at[s]);
      if (roll < 85) return PIN_BITS'(pool_base + PAGE_BITS'($urandom_range(0, n + 2)));
      return PIN_BITS'($urandom_range(0, (1 << PIN_BITS) - 1));
   endfunction

   // Mostly accesses to a pool a bit larger than the active slots (hits and
   // evictions), a few flushes, and some fully random noise.
   function automatic page_request_type pick_request(logic [PAGE_BITS-1:0] pool_base, int n);
      page_request_type     r;
      int                   roll;
      logic [PAGE_BITS-1:0] page;
      roll = $urandom_range(0, 99);
      r.op = (roll < 2) ? OP_FLUSH : OP_ACCESS;
      if (roll < 12) begin
         r.kb    = KB_BITS'($urandom_range(0, (1 << KB_BITS) - 1));
         r.pin_a = PIN_BITS'($urandom_range(0, (1 << PIN_BITS) - 1));
         r.pin_b = PIN_BITS'($urandom_range(0, (1 << PIN_BITS) - 1));
      end else begin
         page    = pool_base + PAGE_BITS'($urandom_range(0, n + 2));
         r.kb    = {page, 4'($urandom_range(0, 15))};
         r.pin_a = pick_pin(pool_base, n);
         r.pin_b = pick_pin(pool_base, n);
      end
      return r;
   endfunction

   initial begin : stimulus
      logic [CFG_BITS-1:0]  modes[12];
      logic [PAGE_BITS-1:0] pool_base;
      int                   n;
      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_op           = OP_ACCESS;
      req_rom_kilobyte = '0;
      req_pin_page_a   = '0;
      req_pin_page_b   = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      gaps_on          = 1'b1;
      dir_check        = new();
      // includes out-of-range counts (0 acts as 1, above SLOTS acts as SLOTS)
      modes = '{5'd16, 5'd3, 5'd1, 5'd8, 5'd0, 5'd5, 5'd2, 5'd31, 5'd12, 5'd4, 5'd17, 5'd16};

      repeat (10) @(negedge clock);
      reset = 1'b0;

      // --- directed: field extremes at the reset slot count ---
      send_request('{OP_FLUSH,  13'd0,    9'd0,   9'd0});    // flush of an empty cache
      send_request('{OP_ACCESS, 13'd0,    9'd0,   9'd0});    // page 0 into slot 0
      send_request('{OP_ACCESS, 13'd15,   9'd511, 9'd0});    // same page, hit
      send_request('{OP_ACCESS, 13'd8191, 9'd511, 9'd511});  // top page
      send_request('{OP_ACCESS, 13'd8176, 9'd0,   9'd511});  // top page again, hit
      send_request('{OP_FLUSH,  13'd8191, 9'd511, 9'd511});

      // two slots: fill, all pinned, LRU victim choice
      write_slot_count(5'd2);
      send_request('{OP_ACCESS, 13'd16, 9'd0, 9'd0});
      send_request('{OP_ACCESS, 13'd32, 9'd0, 9'd0});
      send_request('{OP_ACCESS, 13'd48, 9'd1, 9'd2});        // both slots pinned
      send_request('{OP_ACCESS, 13'd63, 9'd1, 9'd1});        // evicts the unpinned one
      send_request('{OP_ACCESS, 13'd16, 9'd0, 9'd0});        // refresh slot 0
      send_request('{OP_ACCESS, 13'd64, 9'd0, 9'd0});        // oldest is now slot 1

      // count of zero behaves as one slot; slot 1 keeps its page unseen
      write_slot_count(5'd0);
      send_request('{OP_ACCESS, 13'd16,  9'd0, 9'd0});
      send_request('{OP_ACCESS, 13'd64,  9'd0, 9'd0});
      send_request('{OP_ACCESS, 13'd144, 9'd4, 9'd4});       // single slot pinned

      // grow again: retained slots become visible
      write_slot_count(5'd31);
      send_request('{OP_ACCESS, 13'd64, 9'd0, 9'd0});
      send_request('{OP_ACCESS, 13'd16, 9'd0, 9'd0});
      write_slot_count(5'd17);
      send_request('{OP_ACCESS, 13'd16, 9'd0, 9'd0});

      // --- random: one batch per slot-count setting ---
      foreach (modes[m]) begin
         write_slot_count(modes[m]);
         n = int'(modes[m]);
         if (n < 1) n = 1;
         if (n > SLOTS) n = SLOTS;
         pool_base = PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1));
         gaps_on   = !(m == 4 || m == 5);     // a long stretch at full rate
         for (int k = 0; k < ITEMS_PER_MODE; k++) begin
            if (m == 6 && k == 35) wait_drained();  // let the pipe empty mid-batch
            send_request(pick_request(pool_base, n));
         end
      end

      wait_drained();
      repeat (2 * (SLOTS + 2)) @(negedge clock);
      if (dir_check.mismatches == 0 && dir_check.pending_outcomes.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
